### hdl/pfs_pkg.sv
// shared types, constants and threshold tables for the packed float to srgb converter
package pfs_pkg;

    localparam int EXP_W     = 5;
    localparam int EXP_BIAS  = 15;
    localparam int EXP_MAX   = 31;
    localparam int RG_MANT_W = 6;
    localparam int B_MANT_W  = 5;
    localparam int RG_CODE_W = EXP_W + RG_MANT_W;
    localparam int B_CODE_W  = EXP_W + B_MANT_W;
    localparam int RED_LSB   = 0;
    localparam int GREEN_LSB = RED_LSB + RG_CODE_W;
    localparam int BLUE_LSB  = GREEN_LSB + RG_CODE_W;
    localparam int PIXEL_W   = BLUE_LSB + B_CODE_W;

    // channel value as a fixed-point fraction of 2^-20 steps
    localparam int FRAC_W    = 20;
    localparam int THR_W     = FRAC_W + 1;
    localparam int BYTE_W    = 8;
    localparam int TBL_N     = 1 << BYTE_W;
    // decode register plus one register per result bit
    localparam int LANE_DEPTH = BYTE_W + 1;

    // linear segment: v <= 0.0031308, byte = round(v * 12.92 * 255)
    localparam longint LIN_KNEE_NUM = 31308;
    localparam longint LIN_KNEE_DEN = 10000000;
    localparam longint LIN_SLOPE    = 32946;
    localparam longint LIN_DEN      = 10;
    localparam longint LIN_HALF     = 5;
    localparam longint LIN_MAX_L    = (LIN_KNEE_NUM << FRAC_W) / LIN_KNEE_DEN;
    localparam logic [FRAC_W-1:0] LIN_MAX = FRAC_W'(LIN_MAX_L);

    // power segment: v^5 * 269025^12 >= (1000k + 13525)^12 for byte >= k
    localparam int BIG_W       = 384;
    localparam int POW_SCALE   = 269025;
    localparam int POW_STEP    = 1000;
    localparam int POW_OFS     = 13525;
    localparam int POW_NUM_EXP = 5;
    localparam int POW_DEN_EXP = 12;

    typedef logic [TBL_N-1:0][THR_W-1:0] t_thr_tbl;

    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_FULL
    } t_spec;

    typedef struct packed {
        logic valid;
        logic last;
    } t_ctl;

    typedef struct packed {
        logic [BYTE_W-1:0] red;
        logic [BYTE_W-1:0] green;
        logic [BYTE_W-1:0] blue;
        logic              last;
    } t_px;

    // smallest fraction whose linear encoding reaches byte k
    function automatic logic [THR_W-1:0] lin_thr(input int k);
        longint x;
        longint q;
        x = (longint'(k) * LIN_DEN - LIN_HALF) << FRAC_W;
        q = (x + LIN_SLOPE - 1) / LIN_SLOPE;
        if (q > (longint'(1) << FRAC_W)) begin
            q = longint'(1) << FRAC_W;
        end
        return THR_W'(q);
    endfunction

    // smallest fraction whose curve value reaches byte k, exact integer search
    function automatic logic [THR_W-1:0] pow_thr(input int k);
        logic [BIG_W-1:0] c;
        logic [BIG_W-1:0] r;
        logic [BIG_W-1:0] l;
        logic [THR_W-1:0] lo;
        logic [THR_W-1:0] hi;
        logic [THR_W-1:0] mid;
        c = BIG_W'(1);
        r = BIG_W'(1);
        for (int i = 0; i < POW_DEN_EXP; i++) begin
            c = c * BIG_W'(POW_SCALE);
            r = r * BIG_W'(POW_STEP * k + POW_OFS);
        end
        r = r << (POW_NUM_EXP * FRAC_W);
        lo = '0;
        hi = THR_W'(1) << FRAC_W;
        for (int j = 0; j <= FRAC_W; j++) begin
            if (lo < hi) begin
                mid = lo + ((hi - lo) >> 1);
                l = c;
                for (int i = 0; i < POW_NUM_EXP; i++) begin
                    l = l * BIG_W'(mid);
                end
                if (l >= r) begin
                    hi = mid;
                end else begin
                    lo = mid + THR_W'(1);
                end
            end
        end
        return lo;
    endfunction

    function automatic t_thr_tbl build_lin_tbl();
        t_thr_tbl t;
        t = '0;
        for (int k = 1; k < TBL_N; k++) begin
            t[k] = lin_thr(k);
        end
        return t;
    endfunction

    function automatic t_thr_tbl build_pow_tbl();
        t_thr_tbl t;
        t = '0;
        for (int k = 1; k < TBL_N; k++) begin
            t[k] = pow_thr(k);
        end
        return t;
    endfunction

    localparam t_thr_tbl LIN_THR = build_lin_tbl();
    localparam t_thr_tbl POW_THR = build_pow_tbl();

endpackage

### hdl/pfs_lane.sv
// one channel lane: float decode then an 8-step pipelined threshold search
module pfs_lane #(
    parameter int MANT_W = 6
) (
    input  logic                                    i_clk,
    input  logic                                    i_en,
    input  logic [pfs_pkg::EXP_W+MANT_W-1:0]        i_code,
    output logic [pfs_pkg::BYTE_W-1:0]              o_byte
);
    import pfs_pkg::*;

    localparam int CODE_W = EXP_W + MANT_W;
    // shift of the mantissa into the 2^-20 grid is exponent minus this
    localparam int SH_OFS = EXP_BIAS + MANT_W - FRAC_W;

    logic [EXP_W-1:0]  c_exp;
    logic [EXP_W-1:0]  c_exp_eff;
    logic [MANT_W:0]   c_mag;
    logic [EXP_W-1:0]  c_shamt;
    logic [FRAC_W-1:0] c_frac;
    t_spec             c_spec;

    logic [FRAC_W-1:0] r_frac [0:BYTE_W-1];
    logic              r_lin  [0:BYTE_W-1];
    t_spec             r_spec [0:BYTE_W];
    logic [BYTE_W-1:0] r_lo   [0:BYTE_W-1];

    logic [BYTE_W-1:0] c_prev [0:BYTE_W-1];
    logic [BYTE_W-1:0] c_cand [0:BYTE_W-1];
    logic [THR_W-1:0]  c_thr  [0:BYTE_W-1];
    logic [BYTE_W-1:0] n_lo   [0:BYTE_W-1];

    always_comb begin
        c_exp     = i_code[CODE_W-1:MANT_W];
        // a denormal sits on the grid of exponent one without the hidden bit
        c_exp_eff = (c_exp == '0) ? EXP_W'(1) : c_exp;
        c_mag     = {(c_exp != '0), i_code[MANT_W-1:0]};
        c_shamt   = c_exp_eff - EXP_W'(SH_OFS);
        c_frac    = FRAC_W'(c_mag) << c_shamt;
        if (c_exp == EXP_W'(EXP_MAX)) begin
            c_spec = SPEC_ZERO;
        end else if (c_exp >= EXP_W'(EXP_BIAS)) begin
            c_spec = SPEC_FULL;
        end else begin
            c_spec = SPEC_NONE;
        end
    end

    // each stage decides one result bit, msb first
    always_comb begin
        c_prev[0] = '0;
        for (int s = 1; s < BYTE_W; s++) begin
            c_prev[s] = r_lo[s-1];
        end
        for (int s = 0; s < BYTE_W; s++) begin
            c_cand[s] = c_prev[s] | (BYTE_W'(1) << (BYTE_W - 1 - s));
            c_thr[s]  = r_lin[s] ? LIN_THR[c_cand[s]] : POW_THR[c_cand[s]];
            n_lo[s]   = ({1'b0, r_frac[s]} >= c_thr[s]) ? c_cand[s] : c_prev[s];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_frac[0] <= c_frac;
            r_lin[0]  <= (c_frac <= LIN_MAX);
            r_spec[0] <= c_spec;
            for (int s = 0; s < BYTE_W; s++) begin
                r_lo[s]     <= n_lo[s];
                r_spec[s+1] <= r_spec[s];
            end
            for (int s = 1; s < BYTE_W; s++) begin
                r_frac[s] <= r_frac[s-1];
                r_lin[s]  <= r_lin[s-1];
            end
        end
    end

    always_comb begin
        case (r_spec[BYTE_W])
            SPEC_ZERO: o_byte = '0;
            SPEC_FULL: o_byte = '1;
            default:   o_byte = r_lo[BYTE_W-1];
        endcase
    end

endmodule

### hdl/pfs_merge.sv
// merge of the three lane bytes into the output word, with output register and skid slot
module pfs_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfs_pkg::t_ctl                 i_ctl,
    input  logic [pfs_pkg::BYTE_W-1:0]    i_red,
    input  logic [pfs_pkg::BYTE_W-1:0]    i_green,
    input  logic [pfs_pkg::BYTE_W-1:0]    i_blue,
    input  logic                          i_stall,
    output logic                          o_ready,
    output logic                          o_valid,
    output pfs_pkg::t_px                  o_px
);
    import pfs_pkg::*;

    logic r_out_valid;
    logic r_skid_valid;
    t_px  r_out;
    t_px  r_skid;
    logic n_out_valid;
    logic n_skid_valid;
    t_px  n_out;
    t_px  n_skid;
    t_px  c_in;
    logic c_push;
    logic c_free;

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_px    = r_out;

    always_comb begin
        c_in         = '{red: i_red, green: i_green, blue: i_blue, last: i_ctl.last};
        c_push       = i_ctl.valid && !r_skid_valid;
        c_free       = !r_out_valid || !i_stall;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out        = r_out;
        n_skid       = r_skid;
        if (c_free) begin
            if (r_skid_valid) begin
                n_out        = r_skid;
                n_out_valid  = 1'b1;
                n_skid_valid = 1'b0;
            end else if (c_push) begin
                n_out       = c_in;
                n_out_valid = 1'b1;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (c_push) begin
            // output held, park the arriving word
            n_skid       = c_in;
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid slot holds a word while output register is empty");

    a_skid_fill_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall && i_ctl.valid))
        else $error("skid slot filled without a stalled output");

    a_park_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.valid && !r_skid_valid && r_out_valid && i_stall) |=> r_skid_valid)
        else $error("arriving word lost while output stalled");

    a_drain_on_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid slot not drained after output word taken");

endmodule

### hdl/packed_float_pixel_to_srgb.sv
// top level: packed r11g11b10 float pixel to three srgb bytes
// path: lane decode register, threshold-search registers, then merge output register
// throughput: one pixel per clock while o_stall is low; each channel lane runs a
//   decode register and eight threshold-search registers, one result bit per register
// stall: output register plus skid slot; o_stall rises only once the skid slot is full
// reset: synchronous active-low i_rst_n clears all valid flags; no clearing pass
module packed_float_pixel_to_srgb (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [pfs_pkg::PIXEL_W-1:0]     i_packed_pixel,
    input  logic                            i_last_pixel,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [pfs_pkg::BYTE_W-1:0]      o_red_byte,
    output logic [pfs_pkg::BYTE_W-1:0]      o_green_byte,
    output logic [pfs_pkg::BYTE_W-1:0]      o_blue_byte,
    output logic                            o_frame_end
);
    import pfs_pkg::*;

    logic              w_ready;
    logic [BYTE_W-1:0] w_red;
    logic [BYTE_W-1:0] w_green;
    logic [BYTE_W-1:0] w_blue;
    t_ctl              w_ctl;
    t_px               w_px;

    logic r_vld  [0:LANE_DEPTH-1];
    logic r_last [0:LANE_DEPTH-1];

    assign o_stall = !w_ready;

    // valid and last travel beside the lanes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LANE_DEPTH; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_ready) begin
            r_vld[0] <= i_valid;
            for (int s = 1; s < LANE_DEPTH; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready) begin
            r_last[0] <= i_last_pixel;
            for (int s = 1; s < LANE_DEPTH; s++) begin
                r_last[s] <= r_last[s-1];
            end
        end
    end

    pfs_lane #(.MANT_W(RG_MANT_W)) u_lane_red (
        .i_clk  (i_clk),
        .i_en   (w_ready),
        .i_code (i_packed_pixel[RED_LSB +: RG_CODE_W]),
        .o_byte (w_red)
    );

    pfs_lane #(.MANT_W(RG_MANT_W)) u_lane_green (
        .i_clk  (i_clk),
        .i_en   (w_ready),
        .i_code (i_packed_pixel[GREEN_LSB +: RG_CODE_W]),
        .o_byte (w_green)
    );

    pfs_lane #(.MANT_W(B_MANT_W)) u_lane_blue (
        .i_clk  (i_clk),
        .i_en   (w_ready),
        .i_code (i_packed_pixel[BLUE_LSB +: B_CODE_W]),
        .o_byte (w_blue)
    );

    assign w_ctl = '{valid: r_vld[LANE_DEPTH-1], last: r_last[LANE_DEPTH-1]};

    pfs_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_red   (w_red),
        .i_green (w_green),
        .i_blue  (w_blue),
        .i_stall (i_stall),
        .o_ready (w_ready),
        .o_valid (o_valid),
        .o_px    (w_px)
    );

    assign o_red_byte   = w_px.red;
    assign o_green_byte = w_px.green;
    assign o_blue_byte  = w_px.blue;
    assign o_frame_end  = w_px.last;

endmodule

### bench/packed_float_pixel_to_srgb_tb.sv
`timescale 1ns / 1ps
// self-checking bench for the packed float pixel to srgb converter
module packed_float_pixel_to_srgb_tb;

    localparam int     RST_CYCLES  = 8;
    localparam int     RAND_ITEMS  = 1850;
    localparam int     GAP_MAX     = 14;
    localparam int     LATENCY     = 10;
    localparam int     CYCLE_LIMIT = 400000;
    localparam int     PHASE_LEN   = 170;

    // encoding curve constants
    localparam longint KNEE_NUM    = 31308;
    localparam longint KNEE_DEN    = 10000000;
    localparam longint LIN_GAIN    = 32946;
    localparam int     CURVE_SCALE = 269025;
    localparam int     CURVE_STEP  = 1000;
    localparam int     CURVE_OFS   = 13525;

    localparam int     RG_MW       = pfs_pkg::RG_MANT_W;
    localparam int     B_MW        = pfs_pkg::B_MANT_W;

    typedef logic [383:0] t_wide;

    typedef struct packed {
        logic [pfs_pkg::PIXEL_W-1:0] pixel;
        logic                        last;
        logic [3:0]                  gap;
        logic                        drain;
    } t_pixel_item;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n;
    logic                            i_valid;
    logic                            o_stall;
    logic [pfs_pkg::PIXEL_W-1:0]     i_packed_pixel;
    logic                            i_last_pixel;
    logic                            o_valid;
    logic                            i_stall;
    logic [pfs_pkg::BYTE_W-1:0]      o_red_byte;
    logic [pfs_pkg::BYTE_W-1:0]      o_green_byte;
    logic [pfs_pkg::BYTE_W-1:0]      o_blue_byte;
    logic                            o_frame_end;

    t_pixel_item    pixel_q[$];
    pfs_pkg::t_px   srgb_expect_q[$];
    t_pixel_item    next_word;
    logic           have_next = 1'b0;
    logic           pixel_taken = 1'b0;
    int             sent_n = 0;
    int             total_n = 0;
    int             rx_n = 0;
    int             rx_wait = 0;
    int             mismatch_n = 0;
    int             cycle_n = 0;

    packed_float_pixel_to_srgb uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_packed_pixel (i_packed_pixel),
        .i_last_pixel   (i_last_pixel),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_red_byte     (o_red_byte),
        .o_green_byte   (o_green_byte),
        .o_blue_byte    (o_blue_byte),
        .o_frame_end    (o_frame_end)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // srgb byte of one unsigned float code with mant_w mantissa bits
    function automatic logic [7:0] encode_srgb_channel(input int unsigned code,
                                                       input int unsigned mant_w);
        int unsigned  ex;
        int unsigned  man;
        int unsigned  mag;
        int unsigned  sh;
        int unsigned  lo;
        int unsigned  k;
        longint       num;
        longint       den;
        t_wide        lhs;
        t_wide        rhs;
        ex  = code >> mant_w;
        man = code & ((1 << mant_w) - 1);
        if (ex == pfs_pkg::EXP_MAX) begin
            return 8'd0;
        end
        if (ex >= pfs_pkg::EXP_BIAS) begin
            return 8'd255;
        end
        if (ex == 0) begin
            if (man == 0) begin
                return 8'd0;
            end
            mag = man;
            sh  = 14 + mant_w;
        end else begin
            mag = (1 << mant_w) + man;
            sh  = 15 + mant_w - ex;
        end
        // value is mag / 2^sh
        if (longint'(mag) * KNEE_DEN <= (KNEE_NUM << sh)) begin
            num = longint'(mag) * LIN_GAIN + (longint'(5) << sh);
            den = longint'(10) << sh;
            return 8'(num / den);
        end
        lhs = t_wide'(1);
        for (int i = 0; i < 5; i++) begin
            lhs = lhs * t_wide'(mag);
        end
        for (int i = 0; i < 12; i++) begin
            lhs = lhs * t_wide'(CURVE_SCALE);
        end
        // largest k whose rounding threshold the curve still reaches
        lo = 0;
        for (int step = 128; step != 0; step = step >> 1) begin
            k = lo + step;
            rhs = t_wide'(1);
            for (int i = 0; i < 12; i++) begin
                rhs = rhs * t_wide'(CURVE_STEP * k + CURVE_OFS);
            end
            rhs = rhs << (5 * sh);
            if (lhs >= rhs) begin
                lo = k;
            end
        end
        return 8'(lo);
    endfunction

    function automatic pfs_pkg::t_px predict_pixel(input logic [31:0] px, input logic last);
        pfs_pkg::t_px r;
        r.red   = encode_srgb_channel(px[pfs_pkg::RED_LSB +: pfs_pkg::RG_CODE_W], RG_MW);
        r.green = encode_srgb_channel(px[pfs_pkg::GREEN_LSB +: pfs_pkg::RG_CODE_W], RG_MW);
        r.blue  = encode_srgb_channel(px[pfs_pkg::BLUE_LSB +: pfs_pkg::B_CODE_W], B_MW);
        r.last  = last;
        return r;
    endfunction

    function automatic logic [31:0] pack_pixel(input int unsigned r, input int unsigned g,
                                               input int unsigned b);
        return {10'(b), 11'(g), 11'(r)};
    endfunction

    // mostly codes below one so the curve gets exercised
    function automatic int unsigned rand_channel(input int unsigned mant_w);
        int unsigned pick;
        int unsigned ex;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            ex = $urandom_range(0, pfs_pkg::EXP_BIAS - 1);
        end else if (pick < 7) begin
            ex = 0;
        end else begin
            ex = $urandom_range(0, pfs_pkg::EXP_MAX);
        end
        return (ex << mant_w) | ($urandom & ((1 << mant_w) - 1));
    endfunction

    // one phase in three has no waits; the other phases draw random waits
    function automatic int draw_wait(input int n);
        if ((n / PHASE_LEN) % 3 == 0) begin
            return 0;
        end
        return $urandom_range(0, GAP_MAX);
    endfunction

    task automatic add_item(input logic [31:0] px, input logic last, input int gap,
                            input logic drain);
        t_pixel_item it;
        it.pixel = px;
        it.last  = last;
        it.gap   = 4'(gap);
        it.drain = drain;
        pixel_q.push_back(it);
    endtask

    task automatic compare_field(input string name, input logic [7:0] want,
                                 input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_n++;
        end
    endtask

    // handshakes and result checking
    always @(posedge i_clk) begin
        pfs_pkg::t_px want;
        pixel_taken = i_rst_n && i_valid && !o_stall;
        if (pixel_taken) begin
            srgb_expect_q.push_back(predict_pixel(i_packed_pixel, i_last_pixel));
            sent_n++;
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (srgb_expect_q.size() == 0) begin
                $error("unexpected word: red %0d green %0d blue %0d frame_end %0b",
                       o_red_byte, o_green_byte, o_blue_byte, o_frame_end);
                mismatch_n++;
            end else begin
                want = srgb_expect_q.pop_front();
                compare_field("red_byte", want.red, o_red_byte);
                compare_field("green_byte", want.green, o_green_byte);
                compare_field("blue_byte", want.blue, o_blue_byte);
                compare_field("frame_end", 8'(want.last), 8'(o_frame_end));
            end
            rx_n++;
            rx_wait = draw_wait(rx_n + PHASE_LEN / 2);
        end
    end

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pixel_taken) begin
            // stalled word holds
        end else begin
            if (!have_next && pixel_q.size() != 0) begin
                next_word = pixel_q.pop_front();
                have_next = 1'b1;
            end
            if (have_next && next_word.gap == 0 &&
                !(next_word.drain && srgb_expect_q.size() != 0)) begin
                i_packed_pixel <= next_word.pixel;
                i_last_pixel   <= next_word.last;
                i_valid        <= 1'b1;
                have_next       = 1'b0;
            end else begin
                i_valid <= 1'b0;
                if (have_next && next_word.gap != 0) begin
                    next_word.gap = next_word.gap - 4'd1;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n && rx_wait != 0) begin
            i_stall <= 1'b1;
            rx_wait--;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_n++;
        if (cycle_n > CYCLE_LIMIT) begin
            $display("[packed_float_pixel_to_srgb] ERROR");
            $finish;
        end
    end

    initial begin
        logic [31:0] px;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_stall        = 1'b0;
        i_packed_pixel = '0;
        i_last_pixel   = 1'b0;

        // zero, all ones, denormal ends, knee on both sides, one, max, inf, nan
        add_item(32'h0000_0000, 1'b0, 0, 1'b0);
        add_item(32'hffff_ffff, 1'b1, 0, 1'b0);
        add_item(pack_pixel(1, 1, 1), 1'b0, 0, 1'b0);
        add_item(pack_pixel(63, 63, 31), 1'b0, 0, 1'b0);
        add_item(pack_pixel(1 << RG_MW, (1 << RG_MW) | 63, 1 << B_MW), 1'b0, 0, 1'b0);
        add_item(pack_pixel((6 << RG_MW) | 38, (6 << RG_MW) | 39, (6 << B_MW) | 19),
                 1'b0, 0, 1'b0);
        add_item(pack_pixel((6 << RG_MW) | 39, (6 << RG_MW) | 38, (6 << B_MW) | 20),
                 1'b1, 0, 1'b0);
        add_item(pack_pixel((14 << RG_MW) | 63, (14 << RG_MW) | 63, (14 << B_MW) | 31),
                 1'b0, 0, 1'b0);
        add_item(pack_pixel(15 << RG_MW, 15 << RG_MW, 15 << B_MW), 1'b0, 0, 1'b0);
        add_item(pack_pixel((30 << RG_MW) | 63, (30 << RG_MW) | 63, (30 << B_MW) | 31),
                 1'b0, 0, 1'b0);
        add_item(pack_pixel(31 << RG_MW, 31 << RG_MW, 31 << B_MW), 1'b0, 0, 1'b0);
        add_item(pack_pixel((31 << RG_MW) | 1, (31 << RG_MW) | 32, (31 << B_MW) | 16),
                 1'b1, 0, 1'b0);
        add_item(pack_pixel(31 << RG_MW, 0, 15 << B_MW), 1'b0, 0, 1'b0);
        add_item(pack_pixel((10 << RG_MW) | 20, (12 << RG_MW) | 5, (13 << B_MW) | 7),
                 1'b0, 0, 1'b0);
        add_item(pack_pixel(14 << RG_MW, 7 << RG_MW, (3 << B_MW) | 31), 1'b1, 0, 1'b0);

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if ($urandom_range(0, 9) == 0) begin
                px = $urandom;
            end else begin
                px = pack_pixel(rand_channel(RG_MW), rand_channel(RG_MW), rand_channel(B_MW));
            end
            add_item(px, ($urandom_range(0, 15) == 0), draw_wait(i),
                     (i == 0 || i % 400 == 399));
        end
        total_n = pixel_q.size();

        repeat (RST_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (sent_n < total_n) @(negedge i_clk);
        while (srgb_expect_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);

        if (mismatch_n == 0) begin
            $display("[packed_float_pixel_to_srgb] OK");
        end else begin
            $display("[packed_float_pixel_to_srgb] ERROR");
        end
        $finish;
    end

endmodule
